// ----- rtl/ntids_pkg.sv -----
package ntids_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int CMD_W           = 2;
   localparam int HEAD_W          = 64;
   localparam int TAIL_W          = 8;
   localparam int NAME_W          = HEAD_W + TAIL_W;
   localparam int STATUS_W        = 3;
   localparam int SLOT_W          = 4;
   localparam int OCC_W           = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_CREATED  = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_DELETED  = 3'd3,
      ST_NOTFOUND = 3'd4,
      ST_FOUND    = 3'd5,
      ST_LISTED   = 3'd6,
      ST_EMPTY    = 3'd7
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot_index;
      logic [HEAD_W-1:0]  entry_head;
      logic [TAIL_W-1:0]  entry_tail;
      logic [OCC_W-1:0]   occupancy;
      logic               last_of_run;
   } rsp_type;

endpackage

// ----- rtl/ntids_if.sv -----
interface ntids_req_if;
   logic                              valid;
   logic                              ready;
   logic [ntids_pkg::CMD_W-1:0]       cmd;
   logic [ntids_pkg::HEAD_W-1:0]      key_head;
   logic [ntids_pkg::TAIL_W-1:0]      key_tail;

   modport source (output valid, cmd, key_head, key_tail, input ready);
   modport sink   (input valid, cmd, key_head, key_tail, output ready);
endinterface

interface ntids_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ntids_pkg::STATUS_W-1:0]    status;
   logic [ntids_pkg::SLOT_W-1:0]      slot_index;
   logic [ntids_pkg::HEAD_W-1:0]      entry_head;
   logic [ntids_pkg::TAIL_W-1:0]      entry_tail;
   logic [ntids_pkg::OCC_W-1:0]       occupancy;
   logic                              last_of_run;

   modport source (output valid, status, slot_index, entry_head, entry_tail, occupancy,
                   last_of_run, input ready);
   modport sink   (input valid, status, slot_index, entry_head, entry_tail, occupancy,
                   last_of_run, output ready);
endinterface

// ----- rtl/name_table_insert_delete_search_top.sv -----
// channel   dir  handshake              payload
// req_bus   in   valid/ready            cmd, key_head, key_tail
// rsp_bus   out  valid/ready            status, slot_index, entry_head, entry_tail,
//                                       occupancy, last_of_run
//
// Create, delete and search walk the stored names through one 72-bit comparator,
// one entry per cycle behind the RAM's registered read; a delete that hits then
// moves the last entry into the freed slot. List reads each entry and sends it out.
// One transaction at a time; req_bus.ready is low until the last response is taken.
// Synchronous reset empties the table.
module name_table_insert_delete_search_top #(
   parameter int TABLE_DEPTH = ntids_pkg::TABLE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ntids_req_if.sink    req_bus,
   ntids_rsp_if.source  rsp_bus
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic                           ram_we;
   logic [IDX_W-1:0]               ram_waddr;
   logic [ntids_pkg::NAME_W-1:0]   ram_wdata;
   logic                           ram_re;
   logic [IDX_W-1:0]               ram_raddr;
   logic [ntids_pkg::NAME_W-1:0]   ram_rdata;

   ntids_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   ntids_ram #(
      .WIDTH (ntids_pkg::NAME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

`ifndef NO_ASSERTIONS
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready stayed high after an accepted transaction");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !req_bus.ready)
      else $error("table written while idle");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != ntids_pkg::ST_LISTED) |-> rsp_bus.last_of_run)
      else $error("single-result response without last_of_run");
`endif

endmodule

// ----- rtl/ntids_ram.sv -----
module ntids_ram #(
   parameter int WIDTH = ntids_pkg::NAME_W,
   parameter int DEPTH = ntids_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/ntids_ctrl.sv -----
module ntids_ctrl #(
   parameter int TABLE_DEPTH = ntids_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   ntids_req_if.sink                                              req_bus,
   ntids_rsp_if.source                                            rsp_bus,
   output logic                                                   ram_we,
   output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_waddr,
   output logic [ntids_pkg::NAME_W-1:0]                           ram_wdata,
   output logic                                                   ram_re,
   output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] ram_raddr,
   input  logic [ntids_pkg::NAME_W-1:0]                           ram_rdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DEL_RD,
      S_DEL_WR,
      S_LST_RD,
      S_LST_OUT,
      S_RSP
   } state_type;

   state_type            state_ff,   state_in;
   ntids_pkg::cmd_type   cmd_ff,     cmd_in;
   logic [ntids_pkg::NAME_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     count_ff,   count_in;
   logic [CNT_W-1:0]     idx_ff,     idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]     slot_ff,    slot_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   ntids_pkg::rsp_type   rsp_ff,     rsp_in;

   logic                 hit;
   logic [CNT_W-1:0]     count_m1;
   logic [CNT_W-1:0]     idx_nxt;
   logic                 lst_last;

   // single-result transaction: no name payload, always last
   function automatic ntids_pkg::rsp_type make_rsp(ntids_pkg::status_type st,
                                                    logic [CNT_W-1:0] slot,
                                                    logic [CNT_W-1:0] occ);
      ntids_pkg::rsp_type r;
      r.status      = st;
      r.slot_index  = ntids_pkg::SLOT_W'(slot);
      r.entry_head  = '0;
      r.entry_tail  = '0;
      r.occupancy   = ntids_pkg::OCC_W'(occ);
      r.last_of_run = 1'b1;
      return r;
   endfunction

   assign hit      = cmp_vld_ff && (ram_rdata == key_ff);
   assign count_m1 = count_ff - CNT_W'(1);
   assign idx_nxt  = idx_ff + CNT_W'(1);
   assign lst_last = (idx_nxt == count_ff) ||
                     (32'(idx_nxt) == 32'(ntids_pkg::MAX_RESULTS));

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      slot_in    = slot_ff;
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = slot_ff;
      ram_wdata  = key_ff;
      ram_re     = 1'b0;
      ram_raddr  = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in     = ntids_pkg::cmd_type'(req_bus.cmd);
               key_in     = {req_bus.key_head, req_bus.key_tail};
               idx_in     = '0;
               cmp_vld_in = 1'b0;
               if (req_bus.cmd != ntids_pkg::CMD_LIST) begin
                  state_in = S_SCAN;
               end else if (count_ff == '0) begin
                  rsp_in     = make_rsp(ntids_pkg::ST_EMPTY, '0, count_ff);
                  rsp_vld_in = 1'b1;
                  state_in   = S_RSP;
               end else begin
                  state_in = S_LST_RD;
               end
            end
         end

         // read of entry idx overlaps the compare of entry idx-1
         S_SCAN: begin
            ram_re = (idx_ff < count_ff);
            if (hit) begin
               case (cmd_ff)
                  ntids_pkg::CMD_CREATE: begin
                     rsp_in     = make_rsp(ntids_pkg::ST_DUP, '0, count_ff);
                     rsp_vld_in = 1'b1;
                     state_in   = S_RSP;
                  end
                  ntids_pkg::CMD_DELETE: begin
                     slot_in  = cmp_idx_ff[IDX_W-1:0];
                     state_in = S_DEL_RD;
                  end
                  ntids_pkg::CMD_SEARCH: begin
                     rsp_in     = make_rsp(ntids_pkg::ST_FOUND, cmp_idx_ff, count_ff);
                     rsp_vld_in = 1'b1;
                     state_in   = S_RSP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else if (idx_ff == count_ff) begin
               if (cmd_ff == ntids_pkg::CMD_CREATE) begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     rsp_in = make_rsp(ntids_pkg::ST_FULL, '0, count_ff);
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                     rsp_in    = make_rsp(ntids_pkg::ST_CREATED, count_ff, count_in);
                  end
               end else begin
                  rsp_in = make_rsp(ntids_pkg::ST_NOTFOUND, '0, count_ff);
               end
               rsp_vld_in = 1'b1;
               state_in   = S_RSP;
            end else begin
               cmp_vld_in = ram_re;
               cmp_idx_in = idx_ff;
               idx_in     = idx_nxt;
            end
         end

         S_DEL_RD: begin
            ram_re    = 1'b1;
            ram_raddr = count_m1[IDX_W-1:0];
            state_in  = S_DEL_WR;
         end

         // last entry moves into the freed slot; harmless when they coincide
         S_DEL_WR: begin
            ram_we     = 1'b1;
            ram_wdata  = ram_rdata;
            count_in   = count_m1;
            rsp_in     = make_rsp(ntids_pkg::ST_DELETED, CNT_W'(slot_ff), count_m1);
            rsp_vld_in = 1'b1;
            state_in   = S_RSP;
         end

         S_LST_RD: begin
            ram_re   = 1'b1;
            state_in = S_LST_OUT;
         end

         S_LST_OUT: begin
            rsp_in.status      = ntids_pkg::ST_LISTED;
            rsp_in.slot_index  = ntids_pkg::SLOT_W'(idx_ff);
            rsp_in.entry_head  = ram_rdata[ntids_pkg::NAME_W-1:ntids_pkg::TAIL_W];
            rsp_in.entry_tail  = ram_rdata[ntids_pkg::TAIL_W-1:0];
            rsp_in.occupancy   = ntids_pkg::OCC_W'(count_ff);
            rsp_in.last_of_run = lst_last;
            rsp_vld_in         = 1'b1;
            state_in           = S_RSP;
         end

         S_RSP: begin
            if (rsp_bus.ready) begin
               rsp_vld_in = 1'b0;
               if (rsp_ff.last_of_run) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_nxt;
                  state_in = S_LST_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rsp_vld_ff <= rsp_vld_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      slot_ff    <= slot_in;
      rsp_ff     <= rsp_in;
   end

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.status      = rsp_ff.status;
   assign rsp_bus.slot_index  = rsp_ff.slot_index;
   assign rsp_bus.entry_head  = rsp_ff.entry_head;
   assign rsp_bus.entry_tail  = rsp_ff.entry_tail;
   assign rsp_bus.occupancy   = rsp_ff.occupancy;
   assign rsp_bus.last_of_run = rsp_ff.last_of_run;

endmodule

// ----- test/name_table_checker.sv -----
module name_table_checker
   import ntids_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ntids_req_if        req_mon,
   ntids_rsp_if        rsp_mon,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [NAME_W-1:0] dir_names [TABLE_DEPTH_DEF];
   int                dir_count;
   rsp_type           expected_rsps [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      dir_count  = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0d ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int find_slot(input logic [NAME_W-1:0] nm);
      for (int i = 0; i < dir_count; i++) begin
         if (dir_names[i] === nm) return i;
      end
      return -1;
   endfunction

   task automatic predict_op(input logic [CMD_W-1:0] op, input logic [NAME_W-1:0] nm);
      int      hit;
      int      n;
      rsp_type r;
      hit           = find_slot(nm);
      r             = '0;
      r.last_of_run = 1'b1;
      case (cmd_type'(op))
         CMD_CREATE: begin
            // duplicate check wins over full
            if (hit >= 0) begin
               r.status = ST_DUP;
            end else if (dir_count >= TABLE_DEPTH_DEF) begin
               r.status = ST_FULL;
            end else begin
               dir_names[dir_count] = nm;
               r.status             = ST_CREATED;
               r.slot_index         = SLOT_W'(dir_count);
               dir_count++;
            end
            r.occupancy = OCC_W'(dir_count);
            expected_rsps.push_back(r);
         end
         CMD_DELETE: begin
            if (hit >= 0) begin
               // last entry fills the hole; a no-op when it is the last slot
               dir_names[hit] = dir_names[dir_count-1];
               dir_count--;
               r.status       = ST_DELETED;
               r.slot_index   = SLOT_W'(hit);
            end else begin
               r.status = ST_NOTFOUND;
            end
            r.occupancy = OCC_W'(dir_count);
            expected_rsps.push_back(r);
         end
         CMD_SEARCH: begin
            if (hit >= 0) begin
               r.status     = ST_FOUND;
               r.slot_index = SLOT_W'(hit);
            end else begin
               r.status = ST_NOTFOUND;
            end
            r.occupancy = OCC_W'(dir_count);
            expected_rsps.push_back(r);
         end
         default: begin
            if (dir_count == 0) begin
               r.status = ST_EMPTY;
               expected_rsps.push_back(r);
            end else begin
               n = (dir_count > MAX_RESULTS) ? MAX_RESULTS : dir_count;
               for (int i = 0; i < n; i++) begin
                  r.status      = ST_LISTED;
                  r.slot_index  = SLOT_W'(i);
                  r.entry_head  = dir_names[i][NAME_W-1:TAIL_W];
                  r.entry_tail  = dir_names[i][TAIL_W-1:0];
                  r.occupancy   = OCC_W'(dir_count);
                  r.last_of_run = (i == n - 1);
                  expected_rsps.push_back(r);
               end
            end
         end
      endcase
   endtask

   task automatic check_rsp();
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch("unexpected response, status", 64'(rsp_mon.status), 64'd0);
         return;
      end
      want = expected_rsps.pop_front();
      if (rsp_mon.status !== want.status)
         report_mismatch("status", 64'(rsp_mon.status), 64'(want.status));
      if (rsp_mon.slot_index !== want.slot_index)
         report_mismatch("slot_index", 64'(rsp_mon.slot_index), 64'(want.slot_index));
      if (rsp_mon.entry_head !== want.entry_head)
         report_mismatch("entry_head", rsp_mon.entry_head, want.entry_head);
      if (rsp_mon.entry_tail !== want.entry_tail)
         report_mismatch("entry_tail", 64'(rsp_mon.entry_tail), 64'(want.entry_tail));
      if (rsp_mon.occupancy !== want.occupancy)
         report_mismatch("occupancy", 64'(rsp_mon.occupancy), 64'(want.occupancy));
      if (rsp_mon.last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", 64'(rsp_mon.last_of_run), 64'(want.last_of_run));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dir_count = 0;
         expected_rsps.delete();
      end else begin
         // responses first: a transaction's results are all out before the next one
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_rsp();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_op(req_mon.cmd, {req_mon.key_head, req_mon.key_tail});
      end
      pending <= expected_rsps.size();
   end

endmodule

// ----- test/tb_name_table_insert_delete_search_top.sv -----
module tb_name_table_insert_delete_search_top;
   import ntids_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 200;
   localparam int POOL_SIZE    = 24;
   localparam int DRAIN_CYCLES = 64;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   stall_left;
   logic long_stall_go;

   logic [NAME_W-1:0] name_pool [POOL_SIZE];

   ntids_req_if req_if ();
   ntids_rsp_if rsp_if ();

   name_table_insert_delete_search_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   name_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_stall_go) begin
         long_stall_go = 1'b0;
         stall_left    = 150;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [NAME_W-1:0] fresh_name();
      logic [NAME_W-1:0] nm;
      nm = {$urandom, $urandom, 8'($urandom)};
      // short names are zero padded
      if ($urandom_range(3) == 0) nm[39:0] = '0;
      return nm;
   endfunction

   task automatic send_cmd(input cmd_type op, input logic [NAME_W-1:0] nm);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.cmd      <= op;
      req_if.key_head <= nm[NAME_W-1:TAIL_W];
      req_if.key_tail <= nm[TAIL_W-1:0];
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic run_random();
      int      mode;
      int      left;
      int      roll;
      cmd_type op;
      logic [NAME_W-1:0] nm;
      left = 0;
      mode = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 20) long_stall_go = 1'b1;
         if (n == 50) begin
            send_idle_pct = 51;
            recv_idle_pct = 37;
         end
         if (n == 100) begin
            // let the block empty completely before carrying on
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (n == 125) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // episodes biased to fill, drain or mix the table
         if (left == 0) begin
            mode = $urandom_range(2);
            left = $urandom_range(30, 10);
         end
         left--;
         roll = $urandom_range(99);
         case (mode)
            0:       op = (roll < 65) ? CMD_CREATE : (roll < 80) ? CMD_SEARCH :
                          (roll < 90) ? CMD_DELETE : CMD_LIST;
            1:       op = (roll < 65) ? CMD_DELETE : (roll < 80) ? CMD_SEARCH :
                          (roll < 90) ? CMD_CREATE : CMD_LIST;
            default: op = (roll < 30) ? CMD_CREATE : (roll < 60) ? CMD_DELETE :
                          (roll < 90) ? CMD_SEARCH : CMD_LIST;
         endcase
         nm = ($urandom_range(99) < 85) ? name_pool[$urandom_range(POOL_SIZE-1)]
                                        : fresh_name();
         send_cmd(op, nm);
      end
   endtask

   initial begin
      logic [NAME_W-1:0] odd_name;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.cmd      = CMD_CREATE;
      req_if.key_head = '0;
      req_if.key_tail = '0;
      rsp_if.ready    = 1'b0;
      stall_left      = 0;
      long_stall_go   = 1'b0;
      send_idle_pct   = 37;
      recv_idle_pct   = 51;
      // nonzero bytes after a zero byte
      odd_name = {8'h41, 8'h00, 8'h42, 40'h0, 8'h43};
      for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = fresh_name();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_cmd(CMD_LIST, '0);
      send_cmd(CMD_SEARCH, name_pool[0]);
      send_cmd(CMD_CREATE, '0);
      send_cmd(CMD_CREATE, '1);
      send_cmd(CMD_CREATE, odd_name);
      send_cmd(CMD_CREATE, odd_name);
      send_cmd(CMD_DELETE, '0);
      send_cmd(CMD_DELETE, '1);
      for (int i = 0; i < 15; i++) send_cmd(CMD_CREATE, name_pool[i]);
      send_cmd(CMD_CREATE, name_pool[15]);
      send_cmd(CMD_CREATE, odd_name);
      send_cmd(CMD_LIST, '0);

      run_random();

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- name_table_insert_delete_search_top.f -----
rtl/ntids_pkg.sv
rtl/ntids_if.sv
rtl/ntids_ram.sv
rtl/ntids_ctrl.sv
rtl/name_table_insert_delete_search_top.sv
test/name_table_checker.sv
test/tb_name_table_insert_delete_search_top.sv
